>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Holds only clocked property wrappers with an asynchronous reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/cpte_pkg.sv
// Package for the compact-protocol token encoder.
// Holds operation and mode codes, constants and the command type; no dependencies.
package cpte_pkg;
    localparam int NestDepthDefault = 16;

    typedef enum logic [3:0] {
        OP_MSG_BEGIN    = 4'd0,
        OP_STRUCT_BEGIN = 4'd1,
        OP_STRUCT_END   = 4'd2,
        OP_FIELD_BEGIN  = 4'd3,
        OP_FIELD_END    = 4'd4,
        OP_BOOL         = 4'd5,
        OP_BYTE         = 4'd6,
        OP_INT          = 4'd7,
        OP_DOUBLE       = 4'd8,
        OP_LENGTH       = 4'd9,
        OP_DATA_BYTE    = 4'd10,
        OP_LIST_BEGIN   = 4'd11,
        OP_MAP_BEGIN    = 4'd12,
        OP_COLL_END     = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        MODE_CLEAR     = 3'd0,
        MODE_FIELD     = 3'd1,
        MODE_VALUE     = 3'd2,
        MODE_CONTAINER = 3'd3,
        MODE_BOOL      = 3'd4
    } mode_t;

    localparam logic [3:0] TypeBool = 4'd1;
    localparam logic [7:0] MsgMagic = 8'h82;
    localparam logic [7:0] MsgVersion = 8'h02;

    // Command handed from the token decoder to the byte serializer
    typedef struct packed {
        logic [7:0]  pre0;      // first fixed byte
        logic [7:0]  pre1;      // second fixed byte
        logic [1:0]  npre;      // fixed bytes ahead of the body
        logic        has_var;   // varint body follows
        logic        has_raw;   // eight raw bytes follow
        logic [63:0] body;
        logic        has_post;  // one fixed byte after the varint
        logic [7:0]  post;
        logic        err;
    } cmd_t;
endpackage

>>> sv/cpte_serializer.sv
// Byte serializer: shifts a varint out seven bits per cycle or raw bytes eight
// bits per cycle unless stalled, framed by fixed bytes. Depends on cpte_pkg.
module cpte_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  cpte_pkg::cmd_t  cmd,
    output logic            cmd_stall,
    output logic            valid,
    input  logic            stall,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            error
);
    import cpte_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRE  = 5'b00010,
        S_VAR  = 5'b00100,
        S_RAW  = 5'b01000,
        S_POST = 5'b10000
    } sstate_t;

    sstate_t     state_reg, state_next;
    logic [63:0] sh_reg, sh_next;
    logic [7:0]  pre1_reg, pre1_next, post_reg, post_next;
    logic [1:0]  npre_reg, npre_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        hv_reg, hv_next, hr_reg, hr_next, hp_reg, hp_next;
    logic        ov_reg, ov_next, ol_reg, ol_next, oe_reg, oe_next;
    logic [7:0]  ob_reg, ob_next;
    logic        emit;
    logic [7:0]  eb;
    logic        el;

    assign valid = ov_reg;
    assign out_byte = ob_reg;
    assign last = ol_reg;
    assign error = oe_reg;
    // hold the command while busy or while a stalled beat blocks the output
    assign cmd_stall = (state_reg != S_IDLE) || (ov_reg && stall);

    always_comb
    begin
        state_next = state_reg;
        sh_next = sh_reg;
        pre1_next = pre1_reg;
        post_next = post_reg;
        npre_next = npre_reg;
        cnt_next = cnt_reg;
        hv_next = hv_reg;
        hr_next = hr_reg;
        hp_next = hp_reg;
        ov_next = ov_reg && stall;
        ol_next = ol_reg;
        oe_next = oe_reg;
        ob_next = ob_reg;
        emit = 1'b0;
        eb = 8'h00;
        el = 1'b0;
        // the output register must be free before the next byte is produced
        if (!(ov_reg && stall))
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        sh_next = cmd.body;
                        pre1_next = cmd.pre1;
                        post_next = cmd.post;
                        hv_next = cmd.has_var;
                        hr_next = cmd.has_raw;
                        hp_next = cmd.has_post;
                        npre_next = cmd.npre;
                        cnt_next = 3'd7;
                        if (cmd.err)
                        begin
                            ov_next = 1'b1;
                            ob_next = 8'h00;
                            ol_next = 1'b1;
                            oe_next = 1'b1;
                        end
                        else if (cmd.npre != 2'd0)
                        begin
                            emit = 1'b1;
                            eb = cmd.pre0;
                            el = (cmd.npre == 2'd1) && !cmd.has_var && !cmd.has_raw
                                && !cmd.has_post;
                            npre_next = cmd.npre - 2'd1;
                            state_next = el ? S_IDLE
                                : (cmd.npre == 2'd2) ? S_PRE
                                : cmd.has_var ? S_VAR
                                : cmd.has_raw ? S_RAW : S_POST;
                        end
                        else if (cmd.has_var)
                            state_next = S_VAR;
                        else if (cmd.has_raw)
                            state_next = S_RAW;
                        else if (cmd.has_post)
                            state_next = S_POST;
                    end
                end
                S_PRE:
                begin
                    emit = 1'b1;
                    eb = pre1_reg;
                    el = !hv_reg && !hr_reg && !hp_reg;
                    state_next = el ? S_IDLE : hv_reg ? S_VAR : hr_reg ? S_RAW : S_POST;
                end
                S_VAR:
                begin
                    // one seven-bit digit per cycle while the output is not stalled
                    emit = 1'b1;
                    if (sh_reg[63:7] != 57'd0)
                    begin
                        eb = {1'b1, sh_reg[6:0]};
                        sh_next = {7'd0, sh_reg[63:7]};
                    end
                    else
                    begin
                        eb = {1'b0, sh_reg[6:0]};
                        el = !hp_reg;
                        state_next = hp_reg ? S_POST : S_IDLE;
                    end
                end
                S_RAW:
                begin
                    emit = 1'b1;
                    eb = sh_reg[63:56];
                    sh_next = {sh_reg[55:0], 8'h00};
                    cnt_next = cnt_reg - 3'd1;
                    el = (cnt_reg == 3'd0);
                    if (el)
                        state_next = S_IDLE;
                end
                S_POST:
                begin
                    emit = 1'b1;
                    eb = post_reg;
                    el = 1'b1;
                    state_next = S_IDLE;
                end
                default:
                    state_next = S_IDLE;
            endcase
            if (emit)
            begin
                ov_next = 1'b1;
                ob_next = eb;
                ol_next = el;
                oe_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        pre1_reg <= pre1_next;
        post_reg <= post_next;
        npre_reg <= npre_next;
        cnt_reg <= cnt_next;
        hv_reg <= hv_next;
        hr_reg <= hr_next;
        hp_reg <= hp_next;
        ol_reg <= ol_next;
        oe_reg <= oe_next;
        ob_reg <= ob_next;
    end
endmodule

>>> sv/cpte_decoder.sv
// Token decoder: keeps mode, field numbers and the two nesting stacks and
// turns each token into at most one serializer command. Depends on cpte_pkg.
module cpte_decoder #(
    parameter int NEST_DEPTH = cpte_pkg::NestDepthDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [3:0]      operation,
    input  logic [63:0]     value,
    input  logic [15:0]     field_num,
    input  logic [3:0]      type_code,
    input  logic [3:0]      second_type,
    input  logic [2:0]      msg_type,
    output logic            cmd_valid,
    output cpte_pkg::cmd_t  cmd,
    input  logic            cmd_stall
);
    import cpte_pkg::*;

    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int PW = $clog2(NEST_DEPTH + 1);

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] lf_reg, lf_next, pbf_reg, pbf_next;
    logic [PW-1:0] ssp_reg, ssp_next, csp_reg, csp_next;
    logic [18:0] sstack [NEST_DEPTH];
    logic [2:0]  cstack [NEST_DEPTH];
    logic        s_wr, c_wr;
    logic        cv_reg;
    cmd_t        cmd_reg, cmd_next;
    logic        take;
    logic [31:0] size;
    logic [63:0] zz;
    logic [15:0] fh_num;
    logic [3:0]  fh_type;
    logic [16:0] delta;
    logic        do_fh;
    logic [18:0] s_top;
    logic [2:0]  c_top;

    assign in_stall = cv_reg;
    assign take = in_valid && !cv_reg;
    assign cmd_valid = cv_reg;
    assign cmd = cmd_reg;
    assign size = value[31:0];
    assign zz = {value[62:0], 1'b0} ^ {64{value[63]}};
    assign s_top = sstack[AW'(ssp_reg - PW'(1))];
    assign c_top = cstack[AW'(csp_reg - PW'(1))];
    assign delta = {1'b0, fh_num} - {1'b0, lf_reg};

    always_comb
    begin
        mode_next = mode_reg;
        lf_next = lf_reg;
        pbf_next = pbf_reg;
        ssp_next = ssp_reg;
        csp_next = csp_reg;
        s_wr = 1'b0;
        c_wr = 1'b0;
        cmd_next = '0;
        do_fh = 1'b0;
        fh_num = field_num;
        fh_type = type_code;
        case (operation)
            OP_MSG_BEGIN:
            begin
                cmd_next.pre0 = MsgMagic;
                cmd_next.pre1 = MsgVersion | {msg_type, 5'd0};
                cmd_next.npre = 2'd2;
                cmd_next.has_var = 1'b1;
                cmd_next.body = {32'd0, size};
                mode_next = MODE_VALUE;
            end
            OP_STRUCT_BEGIN:
            begin
                if (ssp_reg == PW'(NEST_DEPTH))
                    cmd_next.err = 1'b1;
                else
                begin
                    s_wr = 1'b1;
                    ssp_next = ssp_reg + PW'(1);
                    mode_next = MODE_FIELD;
                    lf_next = 16'd0;
                end
            end
            OP_STRUCT_END:
            begin
                if (ssp_reg == '0)
                    cmd_next.err = 1'b1;
                else
                begin
                    cmd_next.npre = 2'd1;
                    ssp_next = ssp_reg - PW'(1);
                    mode_next = s_top[18:16];
                    lf_next = s_top[15:0];
                end
            end
            OP_FIELD_BEGIN:
            begin
                if (type_code == TypeBool)
                begin
                    mode_next = MODE_BOOL;
                    pbf_next = field_num;
                end
                else
                begin
                    mode_next = MODE_VALUE;
                    do_fh = 1'b1;
                end
            end
            OP_FIELD_END:
                mode_next = MODE_FIELD;
            OP_BOOL:
            begin
                if (mode_reg == MODE_BOOL)
                begin
                    do_fh = 1'b1;
                    fh_num = pbf_reg;
                    fh_type = (value != 64'd0) ? 4'd1 : 4'd2;
                end
                else if (mode_reg == MODE_CONTAINER)
                begin
                    cmd_next.npre = 2'd1;
                    cmd_next.pre0 = (value != 64'd0) ? 8'd1 : 8'd2;
                end
                else
                    cmd_next.err = 1'b1;
            end
            OP_BYTE, OP_DATA_BYTE:
            begin
                cmd_next.npre = 2'd1;
                cmd_next.pre0 = value[7:0];
            end
            OP_INT:
            begin
                cmd_next.has_var = 1'b1;
                cmd_next.body = zz;
            end
            OP_DOUBLE:
            begin
                cmd_next.has_raw = 1'b1;
                cmd_next.body = value;
            end
            OP_LENGTH:
            begin
                cmd_next.has_var = 1'b1;
                cmd_next.body = {32'd0, size};
            end
            OP_LIST_BEGIN, OP_MAP_BEGIN:
            begin
                if (csp_reg == PW'(NEST_DEPTH))
                    cmd_next.err = 1'b1;
                else
                begin
                    c_wr = 1'b1;
                    csp_next = csp_reg + PW'(1);
                    mode_next = MODE_CONTAINER;
                    cmd_next.body = {32'd0, size};
                    if (operation == OP_LIST_BEGIN)
                    begin
                        cmd_next.npre = 2'd1;
                        if (size <= 32'd14)
                            cmd_next.pre0 = {size[3:0], type_code};
                        else
                        begin
                            cmd_next.pre0 = {4'hF, type_code};
                            cmd_next.has_var = 1'b1;
                        end
                    end
                    else if (size == 32'd0)
                        cmd_next.npre = 2'd1;
                    else
                    begin
                        cmd_next.has_var = 1'b1;
                        cmd_next.has_post = 1'b1;
                        cmd_next.post = {type_code, second_type};
                    end
                end
            end
            OP_COLL_END:
            begin
                if (csp_reg == '0)
                    cmd_next.err = 1'b1;
                else
                begin
                    csp_next = csp_reg - PW'(1);
                    mode_next = c_top;
                end
            end
            default:
            begin
            end
        endcase
        if (do_fh)
        begin
            lf_next = fh_num;
            cmd_next.npre = 2'd1;
            if (!delta[16] && delta[15:0] != 16'd0 && delta[15:0] <= 16'd15)
                cmd_next.pre0 = {delta[3:0], fh_type};
            else
            begin
                cmd_next.pre0 = {4'd0, fh_type};
                cmd_next.has_var = 1'b1;
                cmd_next.body = {47'd0, fh_num, 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CLEAR;
            lf_reg <= 16'd0;
            pbf_reg <= 16'd0;
            ssp_reg <= '0;
            csp_reg <= '0;
            cv_reg <= 1'b0;
        end
        else
        begin
            if (cv_reg && !cmd_stall)
                cv_reg <= 1'b0;
            if (take)
            begin
                mode_reg <= mode_next;
                lf_reg <= lf_next;
                pbf_reg <= pbf_next;
                ssp_reg <= ssp_next;
                csp_reg <= csp_next;
                // tokens with nothing to emit and no error drop straight out
                cv_reg <= (cmd_next.npre != 2'd0) || cmd_next.has_var
                    || cmd_next.has_raw || cmd_next.has_post || cmd_next.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
            if (s_wr)
                sstack[AW'(ssp_reg)] <= {mode_reg, lf_reg};
            if (c_wr)
                cstack[AW'(csp_reg)] <= mode_reg;
        end
    end
endmodule

>>> sv/compact_protocol_token_encoder_top.sv
// Compact-protocol token encoder: each accepted token beat yields its encoded
// bytes one per cycle while the output is not stalled. The decoder registers
// the token as a command, and the serializer registers each byte in its output
// register; a token that opens with a varint (integers, lengths, non-empty maps)
// is first loaded into the serializer's shift register. A varint gives up to ten
// bytes, a double eight; varints shift out seven bits a cycle. Tokens emitting
// nothing make no command. Nesting depth is NEST_DEPTH for structs and containers.
module compact_protocol_token_encoder_top #(
    parameter int NEST_DEPTH = cpte_pkg::NestDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [63:0] value,
    input  logic [15:0] field_num,
    input  logic [3:0]  type_code,
    input  logic [3:0]  second_type,
    input  logic [2:0]  msg_type,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error
);
    import cpte_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_stall;

    cpte_decoder #(.NEST_DEPTH(NEST_DEPTH)) u_dec (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .value(value), .field_num(field_num),
        .type_code(type_code), .second_type(second_type), .msg_type(msg_type),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_stall(cmd_stall)
    );

    cpte_serializer u_ser (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_stall(cmd_stall), .valid(out_valid), .stall(out_stall),
        .out_byte(out_byte), .last(last), .error(error)
    );
endmodule

>>> sv/cpte_checker.sv
// Port checker for the compact-protocol token encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module cpte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       error
);
    `CHK_IMPL(a_err_zero, clk, rst_n, out_valid && error, out_byte == 8'h00 && last, "error beat not zero and last")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte), "stalled beat changed")
    `CHK_NEXT(a_err_alone, clk, rst_n, out_valid && !out_stall && !last, !(out_valid && error), "error beat inside a byte run")
endmodule

bind compact_protocol_token_encoder_top cpte_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last(last), .error(error)
);

>>> bench/compact_protocol_token_encoder_top_test.sv
// Testbench for the compact-protocol token encoder top level.
// Drives token beats through a directed table and random streams with some noise,
// predicts the encoded bytes in place and checks every output beat; needs cpte_pkg.
`timescale 1ns / 1ps

module compact_protocol_token_encoder_top_test;
    import cpte_pkg::*;

    localparam int Depth = NestDepthDefault;
    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last_flag;
        logic       err_flag;
    } enc_byte_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] val;
        logic [15:0] fnum;
        logic [3:0]  t1;
        logic [3:0]  t2;
        logic [2:0]  mt;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] operation = '0;
    logic [63:0] value = '0;
    logic [15:0] field_num = '0;
    logic [3:0] type_code = '0;
    logic [3:0] second_type = '0;
    logic [2:0] msg_type = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] out_byte;
    logic last;
    logic error;

    always #1 clk = ~clk;

    compact_protocol_token_encoder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .value(value), .field_num(field_num),
        .type_code(type_code), .second_type(second_type), .msg_type(msg_type),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .last(last), .error(error)
    );

    // encoder state mirror
    mode_t       enc_mode;
    logic [15:0] enc_last_field;
    logic [15:0] enc_bool_field;
    mode_t       struct_mode_stk [Depth];
    logic [15:0] struct_field_stk [Depth];
    int          struct_depth;
    mode_t       coll_mode_stk [Depth];
    int          coll_depth;

    enc_byte_t expected_bytes[$];
    logic [7:0] tok_bytes[$];
    int mismatches = 0;
    int idle_pct = 15;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    task automatic push_varint(input logic [63:0] n);
        while (n[63:7] != '0)
        begin
            tok_bytes.push_back({1'b1, n[6:0]});
            n = n >> 7;
        end
        tok_bytes.push_back(n[7:0]);
    endtask

    function automatic logic [63:0] zigzag(input logic [63:0] u);
        return (u << 1) ^ {64{u[63]}};
    endfunction

    task automatic push_field_header(input logic [15:0] num, input logic [3:0] ty);
        int delta;
        delta = int'(num) - int'(enc_last_field);
        if (delta > 0 && delta <= 15)
            tok_bytes.push_back({delta[3:0], ty});
        else
        begin
            tok_bytes.push_back({4'h0, ty});
            push_varint(zigzag({48'd0, num}));
        end
        enc_last_field = num;
    endtask

    // Work out the bytes one token produces and advance the mirror
    task automatic encode_token(input token_t tk);
        logic [31:0] sz;
        bit bad;
        sz = tk.val[31:0];
        bad = 1'b0;
        tok_bytes.delete();
        case (tk.op)
            OP_MSG_BEGIN:
            begin
                tok_bytes.push_back(MsgMagic);
                tok_bytes.push_back({tk.mt, 5'd2});
                push_varint({32'd0, sz});
                enc_mode = MODE_VALUE;
            end
            OP_STRUCT_BEGIN:
                if (struct_depth >= Depth)
                    bad = 1'b1;
                else
                begin
                    struct_mode_stk[struct_depth] = enc_mode;
                    struct_field_stk[struct_depth] = enc_last_field;
                    struct_depth++;
                    enc_mode = MODE_FIELD;
                    enc_last_field = '0;
                end
            OP_STRUCT_END:
                if (struct_depth == 0)
                    bad = 1'b1;
                else
                begin
                    tok_bytes.push_back(8'h00);
                    struct_depth--;
                    enc_mode = struct_mode_stk[struct_depth];
                    enc_last_field = struct_field_stk[struct_depth];
                end
            OP_FIELD_BEGIN:
                if (tk.t1 == TypeBool)
                begin
                    enc_mode = MODE_BOOL;
                    enc_bool_field = tk.fnum;
                end
                else
                begin
                    enc_mode = MODE_VALUE;
                    push_field_header(tk.fnum, tk.t1);
                end
            OP_FIELD_END: enc_mode = MODE_FIELD;
            OP_BOOL:
                if (enc_mode == MODE_BOOL)
                    push_field_header(enc_bool_field, (tk.val != 0) ? 4'd1 : 4'd2);
                else if (enc_mode == MODE_CONTAINER)
                    tok_bytes.push_back((tk.val != 0) ? 8'd1 : 8'd2);
                else
                    bad = 1'b1;
            OP_BYTE, OP_DATA_BYTE: tok_bytes.push_back(tk.val[7:0]);
            OP_INT: push_varint(zigzag(tk.val));
            OP_DOUBLE:
                for (int i = 7; i >= 0; i--)
                    tok_bytes.push_back(tk.val[i*8 +: 8]);
            OP_LENGTH: push_varint({32'd0, sz});
            OP_LIST_BEGIN, OP_MAP_BEGIN:
                if (coll_depth >= Depth)
                    bad = 1'b1;
                else
                begin
                    if (tk.op == OP_LIST_BEGIN)
                    begin
                        if (sz <= 14)
                            tok_bytes.push_back({sz[3:0], tk.t1});
                        else
                        begin
                            tok_bytes.push_back({4'hf, tk.t1});
                            push_varint({32'd0, sz});
                        end
                    end
                    else if (sz == 0)
                        tok_bytes.push_back(8'h00);
                    else
                    begin
                        push_varint({32'd0, sz});
                        tok_bytes.push_back({tk.t1, tk.t2});
                    end
                    coll_mode_stk[coll_depth] = enc_mode;
                    coll_depth++;
                    enc_mode = MODE_CONTAINER;
                end
            OP_COLL_END:
                if (coll_depth == 0)
                    bad = 1'b1;
                else
                begin
                    coll_depth--;
                    enc_mode = coll_mode_stk[coll_depth];
                end
            default: ;
        endcase
        if (bad)
            tok_bytes = '{8'h00};
        foreach (tok_bytes[k])
            expected_bytes.push_back('{tok_bytes[k], k == tok_bytes.size() - 1, bad});
    endtask

    // Hand one token to the block and predict its bytes; valid stays high
    // between tokens unless an idle cycle is drawn
    task automatic send_token(input token_t tk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= tk.op;
        value <= tk.val;
        field_num <= tk.fnum;
        type_code <= tk.t1;
        second_type <= tk.t2;
        msg_type <= tk.mt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_token(tk);
    endtask

    function automatic token_t mk(input op_t op, input logic [63:0] v = '0,
                                  input logic [15:0] f = '0, input logic [3:0] a = '0,
                                  input logic [3:0] b = '0, input logic [2:0] m = '0);
        return '{op, v, f, a, b, m};
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v = v >> $urandom_range(63);
            1: v = -(v >> $urandom_range(63));
            default: ;
        endcase
        return v;
    endfunction

    // Output side: stall at random and check each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat byte=%h last=%b error=%b",
                                 out_byte, last, error);
                end
                else
                begin
                    enc_byte_t e;
                    e = expected_bytes.pop_front();
                    if (e.byte_val !== out_byte || e.last_flag !== last ||
                        e.err_flag !== error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                     e.byte_val, e.last_flag, e.err_flag,
                                     out_byte, last, error);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WatchdogLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Directed table; the first rows carry their bytes typed in
    token_t dir_tokens[$];
    int     dir_typed_bytes[$][$];

    initial
    begin
        int sent;
        token_t tk;
        dir_tokens = '{
            mk(OP_STRUCT_END), mk(OP_COLL_END), mk(OP_BOOL, 64'd1),
            mk(OP_MSG_BEGIN, 64'hffff_ffff_0000_0001, 0, 0, 0, 3'd7),
            mk(OP_STRUCT_BEGIN), mk(OP_FIELD_BEGIN, 0, 16'd1, 4'd5),
            mk(OP_INT, 64'h8000_0000_0000_0000), mk(OP_INT, 64'h7fff_ffff_ffff_ffff),
            mk(OP_FIELD_END), mk(OP_FIELD_BEGIN, 0, 16'hffff, 4'd15),
            mk(OP_DOUBLE, 64'h0123_4567_89ab_cdef), mk(OP_FIELD_BEGIN, 0, 16'd3, 4'd1),
            mk(OP_BOOL, 64'd0), mk(OP_LENGTH, 64'hffff_ffff_ffff_ffff),
            mk(OP_DATA_BYTE, 64'hff), mk(OP_BYTE, 64'h80),
            mk(OP_LIST_BEGIN, 64'd14, 0, 4'd1), mk(OP_BOOL, 64'd5),
            mk(OP_MAP_BEGIN, 64'd300, 0, 4'd8, 4'd12), mk(OP_MAP_BEGIN, 0),
            mk(op_t'(4'd14)), mk(op_t'(4'd15)), mk(OP_COLL_END), mk(OP_COLL_END),
            mk(OP_LIST_BEGIN, 64'd15, 0, 4'd13), mk(OP_COLL_END), mk(OP_STRUCT_END)
        };
        dir_typed_bytes = '{'{0}, '{0}, '{0}, '{8'h82, 8'he2, 8'h01}};

        enc_mode = MODE_CLEAR;
        enc_last_field = '0;
        enc_bool_field = '0;
        struct_depth = 0;
        coll_depth = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tokens[i])
        begin
            send_token(dir_tokens[i]);
            if (i < dir_typed_bytes.size())
            begin
                if (tok_bytes.size() != dir_typed_bytes[i].size())
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d byte count disagrees", i);
                end
                else
                    for (int k = 0; k < dir_typed_bytes[i].size(); k++)
                        if (tok_bytes[k] != 8'(dir_typed_bytes[i][k]))
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("table row %0d byte %0d disagrees", i, k);
                        end
            end
        end

        // Overflow both stacks, then unwind past empty
        for (int i = 0; i <= Depth; i++)
            send_token(mk(OP_STRUCT_BEGIN));
        for (int i = 0; i <= Depth; i++)
            send_token(mk(OP_LIST_BEGIN, 64'd2, 0, 4'd6));
        for (int i = 0; i <= Depth; i++)
            send_token(mk(OP_COLL_END));
        for (int i = 0; i <= Depth; i++)
            send_token(mk(OP_STRUCT_END));

        // Random streams: mostly structured, some noise
        sent = 0;
        while (sent < 315)
        begin
            if (sent > 100 && sent < 180)
                idle_pct = 0;
            else
                idle_pct = 15;
            case ($urandom_range(9))
                0, 1:
                begin
                    tk = mk(op_t'($urandom_range(15)), rand64(), 16'($urandom),
                            4'($urandom), 4'($urandom), 3'($urandom));
                    if ($urandom_range(1))
                        tk.val = 64'($urandom_range(1));
                end
                2:
                    tk = mk(($urandom_range(1) && struct_depth < Depth + 1) ?
                            OP_STRUCT_BEGIN : OP_STRUCT_END);
                3:
                    tk = mk(($urandom_range(1)) ? OP_LIST_BEGIN : OP_MAP_BEGIN,
                            $urandom_range(3) ? 64'($urandom_range(20)) : rand64(), 0,
                            4'($urandom), 4'($urandom));
                4:
                    tk = mk(OP_COLL_END);
                5:
                    tk = mk(OP_FIELD_BEGIN, 0,
                            $urandom_range(1) ? enc_last_field + 16'($urandom_range(17))
                                              : 16'($urandom),
                            $urandom_range(2) ? 4'($urandom) : TypeBool);
                6:
                    tk = mk(OP_BOOL, $urandom_range(1) ? rand64() : 64'd0);
                7:
                    tk = mk(op_t'($urandom_range(OP_BYTE, OP_DATA_BYTE)), rand64());
                8:
                    tk = mk(OP_MSG_BEGIN, rand64(), 0, 0, 0, 3'($urandom));
                default:
                    tk = mk(OP_FIELD_END);
            endcase
            send_token(tk);
            sent++;
        end
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0 && !timed_out)
        begin
            @(posedge clk);
            if (idle_cycles > WatchdogLimit)
                timed_out = 1'b1;
        end
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0 && !timed_out)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
